[hdl/s256h_pkg.sv]
package s256h_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;
  typedef word_t [15:0] sched_t;

  // Request codes
  localparam logic [1:0] REQ_DATA = 2'd0;
  localparam logic [1:0] REQ_LAST = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  localparam int unsigned BlockBytes = 64;
  localparam logic [5:0] LenPos = 6'd56;   // length field starts here
  localparam logic [7:0] PadMark = 8'h80;

  localparam hash_t InitHash = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

[hdl/sha256_message_hasher_core.sv]
// Streaming SHA-256 hasher. Message bytes come in one transaction at a time
// (req_type_i: data byte, final data byte, or end of message without byte;
// code 3 is accepted and ignored). Bytes are packed big-endian into a 64-byte
// block; every full block is compressed by one shared round unit at one round
// per cycle, and a byte that completes a block waits for its 64 rounds and the
// chaining add before the next byte is taken. At end of message the padding
// (0x80, zeros to byte 56, 64-bit bit length) goes in with the marker and
// zeros one byte per cycle and the length in one write, followed by one or two
// compressions; the eight digest words then leave on the output channel, word
// 0 first, one per output transaction, with last_word_o on word 7. The block
// takes no input from end of message until the last digest word is taken; it
// then restarts from the initial hash. The message length wraps modulo 2^64.
module sha256_message_hasher_core
  import s256h_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  msg_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,   // taking bytes
    ST_PAD,    // inserting padding bytes / length
    ST_ROUND,  // 64 compression rounds
    ST_ADD,    // fold working vars into chaining hash
    ST_OUT     // deliver digest words
  } state_e;

  // where to go once a compression is folded in
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_OUT
  } ret_e;

  state_e      state_q;
  ret_e        ret_q;
  logic [5:0]  fill_q;       // bytes held in current block
  logic [63:0] bits_q;       // message length in bits
  logic [5:0]  round_q;
  logic        pad_first_q;  // next pad byte is the 0x80 marker
  logic [2:0]  out_idx_q;
  hash_t       hash_q;       // chaining hash
  hash_t       vars_q;       // working variables a..h
  sched_t      win_q;        // block buffer, then schedule window

  logic        in_take;
  logic        data_req;
  logic        pad_byte;
  logic        put_en;
  logic [7:0]  put_val;
  logic        len_wr;
  word_t       put_word;
  hash_t       round_vars;
  hash_t       vars_next;
  word_t       w_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_take    = in_valid_i && in_ready_o;
  assign data_req   = (req_type_i == REQ_DATA) || (req_type_i == REQ_LAST);

  // Padding: the marker always goes in, then zeros until the length slot.
  assign pad_byte = (state_q == ST_PAD) && (pad_first_q || (fill_q != LenPos));
  assign len_wr   = (state_q == ST_PAD) && !pad_first_q && (fill_q == LenPos);
  assign put_en   = (in_take && data_req) || pad_byte;
  assign put_val  = (state_q == ST_IDLE) ? msg_byte_i : (pad_first_q ? PadMark : 8'h00);

  // Big-endian byte lane insert; the first byte of a word clears the rest.
  always_comb begin
    if (fill_q[1:0] == 2'd0) begin
      put_word = {put_val, 24'h000000};
    end else begin
      put_word = win_q[fill_q[5:2]];
      put_word[8 * (3 - fill_q[1:0]) +: 8] = put_val;
    end
  end

  // Round 0 starts from the chaining hash directly.
  assign round_vars = (round_q == '0) ? hash_q : vars_q;

  s256h_round u_round (
    .vars_i  (round_vars),
    .win_i   (win_q),
    .k_i     (round_k(round_q)),
    .vars_o  (vars_next),
    .w_new_o (w_new)
  );

  // Block buffer and working variables: payload, no reset.
  always_ff @(posedge clk_i) begin
    if (put_en) begin
      win_q[fill_q[5:2]] <= put_word;
    end
    if (len_wr) begin
      win_q[14] <= bits_q[63:32];
      win_q[15] <= bits_q[31:0];
    end
    if (state_q == ST_ROUND) begin
      win_q  <= {w_new, win_q[15:1]};
      vars_q <= vars_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= RET_IDLE;
      fill_q      <= '0;
      bits_q      <= '0;
      round_q     <= '0;
      pad_first_q <= 1'b0;
      out_idx_q   <= '0;
      hash_q      <= InitHash;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            pad_first_q <= 1'b1;
            if (data_req) begin
              fill_q <= fill_q + 6'd1;
              bits_q <= bits_q + 64'd8;
              if (fill_q == 6'(BlockBytes - 1)) begin
                state_q <= ST_ROUND;
                round_q <= '0;
                ret_q   <= (req_type_i == REQ_LAST) ? RET_PAD : RET_IDLE;
              end else if (req_type_i == REQ_LAST) begin
                state_q <= ST_PAD;
              end
            end else if (req_type_i == REQ_END) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_byte) begin
            fill_q      <= fill_q + 6'd1;
            pad_first_q <= 1'b0;
            if (fill_q == 6'(BlockBytes - 1)) begin
              state_q <= ST_ROUND;
              round_q <= '0;
              ret_q   <= RET_PAD;
            end
          end else begin
            // length written this cycle; final block goes out
            fill_q  <= '0;
            state_q <= ST_ROUND;
            round_q <= '0;
            ret_q   <= RET_OUT;
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + vars_q[i];
          end
          out_idx_q <= '0;
          unique case (ret_q)
            RET_IDLE: state_q <= ST_IDLE;
            RET_PAD:  state_q <= ST_PAD;
            RET_OUT:  state_q <= ST_OUT;
            default:  state_q <= ST_IDLE;
          endcase
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              hash_q  <= InitHash;
              bits_q  <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = hash_q[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 3'd7);

endmodule

[hdl/s256h_round.sv]
// One compression round plus the next message schedule word.
module s256h_round
  import s256h_pkg::*;
(
  input  hash_t  vars_i,
  input  sched_t win_i,
  input  word_t  k_i,
  output hash_t  vars_o,
  output word_t  w_new_o
);

  function automatic word_t ror(word_t v, int unsigned r);
    return (v >> r) | (v << (32 - r));
  endfunction

  word_t big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

  always_comb begin
    big_s1 = ror(vars_i[4], 6) ^ ror(vars_i[4], 11) ^ ror(vars_i[4], 25);
    ch     = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    t1     = vars_i[7] + big_s1 + ch + k_i + win_i[0];
    big_s0 = ror(vars_i[0], 2) ^ ror(vars_i[0], 13) ^ ror(vars_i[0], 22);
    maj    = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t2     = big_s0 + maj;

    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;

    // schedule: W[t+16] from the sliding window
    sm1     = ror(win_i[14], 17) ^ ror(win_i[14], 19) ^ (win_i[14] >> 10);
    sm0     = ror(win_i[1], 7) ^ ror(win_i[1], 18) ^ (win_i[1] >> 3);
    w_new_o = sm1 + win_i[9] + sm0 + win_i[0];
  end

endmodule

[hdl/s256h_chk.sv]
module s256h_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // No intake while the digest is being delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest pending");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word flag mismatch");

  // Words leave in order without gaps.
  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word sequence broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("stalled digest word changed");

endmodule

bind sha256_message_hasher_core s256h_chk u_s256h_chk (.*);
